FILE: design/afs_pkg.sv
// Shared types, constants and register codes for the acceleration feedforward sequencer.
package afs_pkg;

    // Fixed design constants.
    localparam int unsigned IMU_TIMEOUT_MS   = 150;
    localparam int unsigned RETURN_TOLERANCE = 3;
    localparam int unsigned POSITION_CUTOFF  = 26;

    // Derived constants: cutoff and tolerance in 1/16 units, blend reciprocal.
    localparam int unsigned CUTOFF_C    = POSITION_CUTOFF * 16;
    localparam int unsigned CUT_W       = $clog2(CUTOFF_C + 1);
    localparam int unsigned RET_TOL_P   = RETURN_TOLERANCE * 16;
    localparam int unsigned RECIP_SH    = 31;
    localparam logic [31:0] BLEND_RECIP = 32'((64'd1 << RECIP_SH) / CUTOFF_C);

    // Configuration register indexes.
    localparam logic [2:0] CFG_FEED_GAIN     = 3'd0;
    localparam logic [2:0] CFG_FILTER_ALPHA  = 3'd1;
    localparam logic [2:0] CFG_MAX_OFFSET    = 3'd2;
    localparam logic [2:0] CFG_ENTER_THRESH  = 3'd3;
    localparam logic [2:0] CFG_EXIT_THRESH   = 3'd4;
    localparam logic [2:0] CFG_ENTER_CONFIRM = 3'd5;
    localparam logic [2:0] CFG_EXIT_CONFIRM  = 3'd6;
    localparam logic [2:0] CFG_RETURN_TMO    = 3'd7;

    // Configuration reset values.
    localparam logic [15:0] RST_FEED_GAIN     = 16'd901;
    localparam logic [15:0] RST_FILTER_ALPHA  = 16'd22938;
    localparam logic [14:0] RST_MAX_OFFSET    = 15'd15360;
    localparam logic [14:0] RST_ENTER_THRESH  = 15'd25;
    localparam logic [14:0] RST_EXIT_THRESH   = 15'd10;
    localparam logic [15:0] RST_ENTER_CONFIRM = 16'd10;
    localparam logic [15:0] RST_EXIT_CONFIRM  = 16'd100;
    localparam logic [15:0] RST_RETURN_TMO    = 16'd350;

    // Control modes.
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_ACTIVE = 2'd1,
        MODE_RETURN = 2'd2
    } ctrl_mode_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_FILTER,
        SEQ_PRODUCT,
        SEQ_SCALE,
        SEQ_COMMIT
    } seq_state_t;

    // Datapath step commands from the controller.
    typedef struct packed {
        logic load;
        logic filter;
        logic product;
        logic scale;
        logic commit;
    } afs_cmd_t;

    typedef struct packed {
        logic               action;
        logic signed [15:0] accel_sample;
        logic signed [15:0] vision_err;
        logic signed [31:0] commanded_pulse;
        logic signed [31:0] measured_pulse;
        logic               feedback_valid;
        logic               enable_ff;
        logic        [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic        [1:0]  mode;
        logic signed [15:0] target_offset;
        logic        [16:0] blend_weight;
        logic signed [31:0] entry_pulse;
        logic signed [23:0] filtered_accel;
        logic               timed_out;
        logic               ctrl_was_active;
    } out_item_t;

endpackage

FILE: design/afs_ctrl.sv
// Sequencer state machine: walks one item through the datapath steps and owns the result valid.
module afs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output afs_pkg::afs_cmd_t cmd
);

    afs_pkg::seq_state_t state_reg, state_next;
    logic                m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= afs_pkg::SEQ_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            afs_pkg::SEQ_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = afs_pkg::SEQ_FILTER;
                end
            end
            afs_pkg::SEQ_FILTER: begin
                cmd.filter = 1'b1;
                state_next = afs_pkg::SEQ_PRODUCT;
            end
            afs_pkg::SEQ_PRODUCT: begin
                cmd.product = 1'b1;
                state_next  = afs_pkg::SEQ_SCALE;
            end
            afs_pkg::SEQ_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = afs_pkg::SEQ_COMMIT;
            end
            afs_pkg::SEQ_COMMIT: begin
                // wait for the output slot to free up
                if (!m_valid_reg || m_ready) begin
                    cmd.commit = 1'b1;
                    state_next = afs_pkg::SEQ_IDLE;
                end
            end
            default: state_next = afs_pkg::SEQ_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == afs_pkg::SEQ_FILTER))
        else $error("accepted item did not start the filter step");

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid_reg)
        else $error("committed result not presented");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == afs_pkg::SEQ_COMMIT && m_valid_reg && !m_ready)
        |=> (state_reg == afs_pkg::SEQ_COMMIT))
        else $error("commit overran a pending result");

endmodule

FILE: design/afs_datapath.sv
// Datapath: config registers, filter and sequencer state, shared multiply steps, result register.
module afs_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  afs_pkg::afs_cmd_t  cmd,
    input  afs_pkg::in_item_t  s_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    output afs_pkg::out_item_t m_data
);

    // configuration
    logic signed [15:0] gain_reg;
    logic        [15:0] alpha_reg;
    logic        [14:0] maxoff_reg;
    logic        [14:0] enter_th_reg;
    logic        [14:0] exit_th_reg;
    logic        [15:0] enter_ms_reg;
    logic        [15:0] exit_ms_reg;
    logic        [15:0] ret_ms_reg;

    // sequencer state
    afs_pkg::ctrl_mode_t mode_reg, mode_next;
    logic signed [24:0]  f_reg, f_next;
    logic                seen_reg, seen_next;
    logic        [31:0]  last_reg, last_next;
    logic        [31:0]  conf_reg, conf_next;
    logic        [31:0]  rstart_reg, rstart_next;
    logic                entf_reg, entf_next;
    logic                exf_reg, exf_next;
    logic signed [31:0]  bcmd_reg, bcmd_next;
    logic signed [31:0]  bmeas_reg, bmeas_next;
    logic signed [15:0]  off_reg, off_next;
    logic        [16:0]  blend_reg, blend_next;

    // working registers
    afs_pkg::in_item_t                in_reg;
    logic signed [42:0]               prod_f_reg;
    logic                             in_cut_reg;
    logic        [afs_pkg::CUT_W-1:0] d_reg;
    logic signed [24:0]               fnew_reg;
    logic        [48:0]               prod_b_reg;
    logic signed [40:0]               prod_g_reg;
    logic        [16:0]               qest_reg;
    logic        [32:0]               qc_reg;
    afs_pkg::out_item_t               out_reg, out_next;

    // step combinational values
    logic signed [25:0]  diff;
    logic        [16:0]  e_abs;
    logic signed [42:0]  prod_f_rnd;
    logic signed [26:0]  f_sum;
    logic        [16:0]  qest;
    logic        [32:0]  num;
    logic        [32:0]  rem;
    logic        [16:0]  blend_val;
    logic signed [40:0]  prod_g_rnd;
    logic signed [28:0]  og;
    logic signed [28:0]  lim;
    logic signed [28:0]  off_wide;
    logic signed [15:0]  off_sat;
    logic        [24:0]  f_abs;
    logic                gap;
    logic signed [32:0]  pipe_diff;
    logic        [32:0]  pipe_abs;
    logic                do_reset;
    logic                timed;
    logic                was_ctrl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg     <= afs_pkg::RST_FEED_GAIN;
            alpha_reg    <= afs_pkg::RST_FILTER_ALPHA;
            maxoff_reg   <= afs_pkg::RST_MAX_OFFSET;
            enter_th_reg <= afs_pkg::RST_ENTER_THRESH;
            exit_th_reg  <= afs_pkg::RST_EXIT_THRESH;
            enter_ms_reg <= afs_pkg::RST_ENTER_CONFIRM;
            exit_ms_reg  <= afs_pkg::RST_EXIT_CONFIRM;
            ret_ms_reg   <= afs_pkg::RST_RETURN_TMO;
        end else if (cfg_we) begin
            unique case (cfg_index)
                afs_pkg::CFG_FEED_GAIN:     gain_reg     <= cfg_wdata;
                afs_pkg::CFG_FILTER_ALPHA:  alpha_reg    <= cfg_wdata;
                afs_pkg::CFG_MAX_OFFSET:    maxoff_reg   <= cfg_wdata[14:0];
                afs_pkg::CFG_ENTER_THRESH:  enter_th_reg <= cfg_wdata[14:0];
                afs_pkg::CFG_EXIT_THRESH:   exit_th_reg  <= cfg_wdata[14:0];
                afs_pkg::CFG_ENTER_CONFIRM: enter_ms_reg <= cfg_wdata;
                afs_pkg::CFG_EXIT_CONFIRM:  exit_ms_reg  <= cfg_wdata;
                afs_pkg::CFG_RETURN_TMO:    ret_ms_reg   <= cfg_wdata;
                default:                    gain_reg     <= gain_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= afs_pkg::MODE_IDLE;
            f_reg      <= '0;
            seen_reg   <= 1'b0;
            last_reg   <= '0;
            conf_reg   <= '0;
            rstart_reg <= '0;
            entf_reg   <= 1'b0;
            exf_reg    <= 1'b0;
            bcmd_reg   <= '0;
            bmeas_reg  <= '0;
            off_reg    <= '0;
            blend_reg  <= '0;
        end else if (cmd.commit) begin
            mode_reg   <= mode_next;
            f_reg      <= f_next;
            seen_reg   <= seen_next;
            last_reg   <= last_next;
            conf_reg   <= conf_next;
            rstart_reg <= rstart_next;
            entf_reg   <= entf_next;
            exf_reg    <= exf_next;
            bcmd_reg   <= bcmd_next;
            bmeas_reg  <= bmeas_next;
            off_reg    <= off_next;
            blend_reg  <= blend_next;
        end
    end

    // filter step: difference times alpha; blend numerator
    assign diff  = $signed({{2{in_reg.accel_sample[15]}}, in_reg.accel_sample, 8'd0})
                 - $signed({f_reg[24], f_reg});
    assign e_abs = in_reg.vision_err[15]
                 ? 17'(-$signed({in_reg.vision_err[15], in_reg.vision_err}))
                 : {1'b0, in_reg.vision_err};

    // product step: round and accumulate, blend reciprocal multiply
    assign prod_f_rnd = prod_f_reg + 43'sd32768;
    assign f_sum      = $signed({{2{f_reg[24]}}, f_reg}) + prod_f_rnd[42:16];

    // scale step: quotient estimate d * 65536 / C, low by at most one
    assign qest = prod_b_reg[(afs_pkg::RECIP_SH - 16) +: 17];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg <= s_data;
        end
        if (cmd.filter) begin
            prod_f_reg <= $signed({{26{1'b0}}, alpha_reg})
                        * $signed({{17{diff[25]}}, diff});
            in_cut_reg <= (e_abs < 17'(afs_pkg::CUTOFF_C));
            d_reg      <= afs_pkg::CUT_W'(17'(afs_pkg::CUTOFF_C) - e_abs);
        end
        if (cmd.product) begin
            fnew_reg   <= f_sum[24:0];
            prod_b_reg <= {{(49 - afs_pkg::CUT_W){1'b0}}, d_reg} * {17'd0, afs_pkg::BLEND_RECIP};
        end
        if (cmd.scale) begin
            prod_g_reg <= $signed({{25{gain_reg[15]}}, gain_reg})
                        * $signed({{16{fnew_reg[24]}}, fnew_reg});
            qest_reg   <= qest;
            qc_reg     <= {16'd0, qest} * 33'(afs_pkg::CUTOFF_C);
        end
        if (cmd.commit) begin
            out_reg <= out_next;
        end
    end

    // commit step: blend correction, offset saturation
    assign num       = 33'({d_reg, 16'd0});
    assign rem       = num - qc_reg;
    assign blend_val = !in_cut_reg ? 17'd0
                     : (rem >= 33'(afs_pkg::CUTOFF_C)) ? 17'(qest_reg + 17'd1) : qest_reg;

    assign prod_g_rnd = prod_g_reg + 41'sd2048;
    assign og         = prod_g_rnd[40:12];
    assign lim        = $signed({14'd0, maxoff_reg});
    always_comb begin
        if (og > lim) begin
            off_wide = lim;
        end else if (og < -lim) begin
            off_wide = -lim;
        end else begin
            off_wide = og;
        end
    end
    assign off_sat = off_wide[15:0];

    assign f_abs     = fnew_reg[24] ? 25'(-fnew_reg) : fnew_reg;
    assign gap       = (in_reg.now_ms - last_reg) > 32'(afs_pkg::IMU_TIMEOUT_MS);
    assign pipe_diff = $signed({bmeas_reg[31], bmeas_reg})
                     - $signed({in_reg.measured_pulse[31], in_reg.measured_pulse});
    assign pipe_abs  = pipe_diff[32] ? 33'(-pipe_diff) : pipe_diff;

    always_comb begin
        mode_next   = mode_reg;
        f_next      = f_reg;
        seen_next   = seen_reg;
        last_next   = last_reg;
        conf_next   = conf_reg;
        rstart_next = rstart_reg;
        entf_next   = entf_reg;
        exf_next    = exf_reg;
        bcmd_next   = bcmd_reg;
        bmeas_next  = bmeas_reg;
        off_next    = off_reg;
        blend_next  = blend_reg;
        do_reset    = 1'b0;
        timed       = 1'b0;
        was_ctrl    = 1'b0;

        if (!in_reg.action) begin
            if (!seen_reg || gap) begin
                // first sample or stale filter: reseed
                f_next    = $signed({in_reg.accel_sample[15], in_reg.accel_sample, 8'd0});
                seen_next = 1'b1;
                last_next = in_reg.now_ms;
                do_reset  = 1'b1;
            end else begin
                last_next = in_reg.now_ms;
                f_next    = fnew_reg;
                if (!in_reg.enable_ff || !in_reg.feedback_valid) begin
                    do_reset = 1'b1;
                end else begin
                    blend_next = blend_val;
                    if (mode_reg == afs_pkg::MODE_IDLE) begin
                        off_next   = '0;
                        blend_next = '0;
                        if (!in_cut_reg) begin
                            entf_next = 1'b0;
                        end else if (f_abs >= {2'd0, enter_th_reg, 8'd0}) begin
                            if (!entf_reg) begin
                                bcmd_next  = in_reg.commanded_pulse;
                                bmeas_next = in_reg.measured_pulse;
                                conf_next  = in_reg.now_ms;
                                entf_next  = 1'b1;
                            end else if ((in_reg.now_ms - conf_reg) >= {16'd0, enter_ms_reg}) begin
                                mode_next = afs_pkg::MODE_ACTIVE;
                                entf_next = 1'b0;
                            end
                        end else begin
                            entf_next = 1'b0;
                        end
                    end

                    if (mode_next == afs_pkg::MODE_ACTIVE) begin
                        blend_next = blend_val;
                        if (!in_cut_reg) begin
                            do_reset = 1'b1;
                        end else begin
                            off_next = off_sat;
                            if (f_abs <= {2'd0, exit_th_reg, 8'd0}) begin
                                if (!exf_next) begin
                                    conf_next = in_reg.now_ms;
                                    exf_next  = 1'b1;
                                end else if ((in_reg.now_ms - conf_next)
                                             >= {16'd0, exit_ms_reg}) begin
                                    mode_next   = afs_pkg::MODE_RETURN;
                                    off_next    = '0;
                                    rstart_next = in_reg.now_ms;
                                    exf_next    = 1'b0;
                                end
                            end else begin
                                exf_next = 1'b0;
                            end
                        end
                    end else if (mode_next == afs_pkg::MODE_RETURN) begin
                        off_next = '0;
                        if (!in_cut_reg || pipe_abs <= 33'(afs_pkg::RET_TOL_P)
                            || (in_reg.now_ms - rstart_reg) >= {16'd0, ret_ms_reg}) begin
                            do_reset = 1'b1;
                        end
                    end
                end
            end
        end else if (seen_reg && gap) begin
            // timeout check found a stale sample stream
            was_ctrl  = (mode_reg != afs_pkg::MODE_IDLE);
            timed     = 1'b1;
            seen_next = 1'b0;
            f_next    = '0;
            do_reset  = 1'b1;
        end

        if (do_reset) begin
            mode_next   = afs_pkg::MODE_IDLE;
            bcmd_next   = in_reg.commanded_pulse;
            bmeas_next  = '0;
            off_next    = '0;
            blend_next  = '0;
            conf_next   = '0;
            rstart_next = '0;
            entf_next   = 1'b0;
            exf_next    = 1'b0;
        end

        out_next.mode            = mode_next;
        out_next.target_offset   = off_next;
        out_next.blend_weight    = blend_next;
        out_next.entry_pulse     = bcmd_next;
        out_next.filtered_accel  = f_next[23:0];
        out_next.timed_out       = timed;
        out_next.ctrl_was_active = was_ctrl;
    end

    assign m_data = out_reg;

    a_enter_flag_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        entf_reg |-> (mode_reg == afs_pkg::MODE_IDLE))
        else $error("entering flag set outside idle");

    a_exit_flag_active: assert property (@(posedge aclk) disable iff (!aresetn)
        exf_reg |-> (mode_reg == afs_pkg::MODE_ACTIVE))
        else $error("exiting flag set outside active");

    a_unseen_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !seen_reg |-> (mode_reg == afs_pkg::MODE_IDLE && f_reg == '0))
        else $error("control or filter running without a sample");

endmodule

FILE: design/accel_feedforward_sequencer.sv
// Top level of the acceleration feedforward sequencer: controller plus datapath.
//
// Usage:
//   Input channel s_valid/s_ready/s_data carries one item per transfer: either an
//   acceleration sample update (action 0) or a timeout check (action 1).
//   Output channel m_valid/m_ready/m_data returns exactly one result per item:
//   mode, feedforward offset (Q8.8), blend weight (Q1.16), captured baseline,
//   filtered acceleration (Q16.8) and the timeout flags.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index at the clock
//   edge, no wait. Write only while no item is in flight.
// Sequencing:
//   The item walks four sequencer steps (filter multiply, accumulate and blend
//   reciprocal multiply, gain multiply and quotient check, commit), in order
//   on the shared datapath. The result is registered at commit, and a new item
//   is taken only after the previous one has committed.
// Reset (aresetn low, synchronous): config registers return to their defaults, mode is
//   idle, the filter is cleared and no sample is marked seen.
// Stall: if the receiver holds m_ready low, the result stays in the output
//   register; one more item is accepted and processed, then waits at commit.
module accel_feedforward_sequencer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  afs_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output afs_pkg::out_item_t m_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wdata
);

    // step commands from the sequencer to the datapath
    afs_pkg::afs_cmd_t cmd;

    afs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // all arithmetic, state and the result register live here
    afs_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_data    (m_data)
    );

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the acceleration feedforward sequencer.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Action codes carried in the input item.
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_CHECK  = 1'b1;

    // Fixed block parameters in the units the sequencer compares against.
    localparam logic [31:0] STALE_MS   = 32'd150;   // IMU gap limit
    localparam longint      HOME_TOL   = 3 * 16;    // return tolerance, 1/16 pulse
    localparam longint      BLEND_SPAN = 26 * 16;   // blend cutoff, 1/16 pixel

    localparam int DRAIN_CYCLES = 12;    // wait after the last expected result
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int QUIET_LIMIT  = 2000;  // cycles without any transfer

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    afs_pkg::in_item_t  s_data    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    afs_pkg::out_item_t m_data;
    logic               cfg_we    = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_wdata = '0;

    accel_feedforward_sequencer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Sequencer prediction: own copy of registers and control state.
    // ------------------------------------------------------------------
    logic [31:0]         reg_val [8];
    afs_pkg::ctrl_mode_t seq_mode;
    longint              lp_accel;      // Q16.8 filtered acceleration
    bit                  got_sample;
    logic [31:0]         last_ms;
    logic [31:0]         confirm_ms;
    logic [31:0]         return_ms;
    bit                  entering;
    bit                  exiting;
    logic signed [31:0]  base_cmd;
    logic signed [31:0]  base_meas;
    longint              offset_q;      // Q8.8
    longint              blend_q;       // Q1.16

    afs_pkg::out_item_t expected_results [$];
    int                 errors = 0;

    // Stimulus knobs shared with the driver processes.
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_requests = 0;
    logic [15:0] next_cfg [8];

    // Random scenario state: a drifting clock and acceleration episodes.
    logic [31:0] clock_ms;
    int          accel_level = 0;
    int          episode_left = 0;
    logic [31:0] cmd_center;
    logic [31:0] meas_center;

    function automatic void clear_control(input logic signed [31:0] cmd);
        seq_mode   = afs_pkg::MODE_IDLE;
        base_cmd   = cmd;
        base_meas  = '0;
        offset_q   = 0;
        blend_q    = 0;
        confirm_ms = '0;
        return_ms  = '0;
        entering   = 1'b0;
        exiting    = 1'b0;
    endfunction

    function automatic void model_reset();
        reg_val[afs_pkg::CFG_FEED_GAIN]     = 32'd901;
        reg_val[afs_pkg::CFG_FILTER_ALPHA]  = 32'd22938;
        reg_val[afs_pkg::CFG_MAX_OFFSET]    = 32'd15360;
        reg_val[afs_pkg::CFG_ENTER_THRESH]  = 32'd25;
        reg_val[afs_pkg::CFG_EXIT_THRESH]   = 32'd10;
        reg_val[afs_pkg::CFG_ENTER_CONFIRM] = 32'd10;
        reg_val[afs_pkg::CFG_EXIT_CONFIRM]  = 32'd100;
        reg_val[afs_pkg::CFG_RETURN_TMO]    = 32'd350;
        lp_accel   = 0;
        got_sample = 1'b0;
        last_ms    = '0;
        clear_control('0);
    endfunction

    function automatic logic [15:0] reg_mask(input logic [2:0] idx);
        unique case (idx)
            afs_pkg::CFG_MAX_OFFSET, afs_pkg::CFG_ENTER_THRESH,
            afs_pkg::CFG_EXIT_THRESH: return 16'h7FFF;
            default: return 16'hFFFF;
        endcase
    endfunction

    // Sample update: low-pass, then idle / active / returning sequencing.
    function automatic void apply_sample(input afs_pkg::in_item_t it);
        longint      smp, err_abs, f_abs, blend, off, lim, drift;
        logic [31:0] since_last, elapsed;
        smp = longint'(it.accel_sample);
        since_last = it.now_ms - last_ms;
        if (!got_sample || since_last > STALE_MS) begin
            // first sample or stale IMU: reseed filter, drop control
            lp_accel   = smp * 256;
            got_sample = 1'b1;
            last_ms    = it.now_ms;
            clear_control(it.commanded_pulse);
            return;
        end
        last_ms  = it.now_ms;
        lp_accel = lp_accel
                 + ((longint'(reg_val[afs_pkg::CFG_FILTER_ALPHA]) * (smp * 256 - lp_accel)
                    + 32768) >>> 16);
        if (!it.enable_ff || !it.feedback_valid) begin
            clear_control(it.commanded_pulse);
            return;
        end

        err_abs = longint'(it.vision_err);
        if (err_abs < 0) err_abs = -err_abs;
        blend   = (err_abs >= BLEND_SPAN) ? 0 : ((BLEND_SPAN - err_abs) * 65536) / BLEND_SPAN;
        blend_q = blend;
        f_abs   = (lp_accel < 0) ? -lp_accel : lp_accel;

        if (seq_mode == afs_pkg::MODE_IDLE) begin
            offset_q = 0;
            blend_q  = 0;
            if (err_abs >= BLEND_SPAN) begin
                entering = 1'b0;
            end else if (f_abs >= longint'(reg_val[afs_pkg::CFG_ENTER_THRESH]) * 256) begin
                if (!entering) begin
                    base_cmd   = it.commanded_pulse;
                    base_meas  = it.measured_pulse;
                    confirm_ms = it.now_ms;
                    entering   = 1'b1;
                end else begin
                    elapsed = it.now_ms - confirm_ms;
                    if (elapsed >= reg_val[afs_pkg::CFG_ENTER_CONFIRM]) begin
                        seq_mode = afs_pkg::MODE_ACTIVE;
                        entering = 1'b0;
                    end
                end
            end else begin
                entering = 1'b0;
            end
        end

        if (seq_mode == afs_pkg::MODE_ACTIVE) begin
            blend_q = blend;
            if (blend <= 0) begin
                clear_control(it.commanded_pulse);
                return;
            end
            off = (longint'($signed(reg_val[afs_pkg::CFG_FEED_GAIN][15:0])) * lp_accel
                   + 2048) >>> 12;
            lim = longint'(reg_val[afs_pkg::CFG_MAX_OFFSET]);
            if (off > lim) off = lim;
            if (off < -lim) off = -lim;
            offset_q = off;
            if (f_abs <= longint'(reg_val[afs_pkg::CFG_EXIT_THRESH]) * 256) begin
                if (!exiting) begin
                    confirm_ms = it.now_ms;
                    exiting    = 1'b1;
                end else begin
                    elapsed = it.now_ms - confirm_ms;
                    if (elapsed >= reg_val[afs_pkg::CFG_EXIT_CONFIRM]) begin
                        seq_mode  = afs_pkg::MODE_RETURN;
                        offset_q  = 0;
                        return_ms = it.now_ms;
                        exiting   = 1'b0;
                    end
                end
            end else begin
                exiting = 1'b0;
            end
        end else if (seq_mode == afs_pkg::MODE_RETURN) begin
            offset_q = 0;
            drift = longint'(base_meas) - longint'(it.measured_pulse);
            if (drift < 0) drift = -drift;
            elapsed = it.now_ms - return_ms;
            if (blend <= 0 || drift <= HOME_TOL
                || elapsed >= reg_val[afs_pkg::CFG_RETURN_TMO])
                clear_control(it.commanded_pulse);
        end
    endfunction

    // One accepted item -> the result the block must return for it.
    function automatic afs_pkg::out_item_t sequencer_step(input afs_pkg::in_item_t it);
        afs_pkg::out_item_t res;
        logic               tmo, was_on;
        logic [31:0]        since_last;
        tmo    = 1'b0;
        was_on = 1'b0;
        if (it.action == ACT_SAMPLE) begin
            apply_sample(it);
        end else begin
            since_last = it.now_ms - last_ms;
            if (got_sample && since_last > STALE_MS) begin
                was_on     = (seq_mode != afs_pkg::MODE_IDLE);
                tmo        = 1'b1;
                got_sample = 1'b0;
                lp_accel   = 0;
                clear_control(it.commanded_pulse);
            end
        end
        res.mode            = seq_mode;
        res.target_offset   = offset_q[15:0];
        res.blend_weight    = blend_q[16:0];
        res.entry_pulse     = base_cmd;
        res.filtered_accel  = lp_accel[23:0];
        res.timed_out       = tmo;
        res.ctrl_was_active = was_on;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checking against the oldest pending expectation.
    // ------------------------------------------------------------------
    task automatic check_result(input afs_pkg::out_item_t got);
        afs_pkg::out_item_t want;
        if (expected_results.size() == 0) begin
            $error("result transfer with nothing pending: %h", got);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        if (got.mode !== want.mode) begin
            $error("mode: expected %0d, got %0d", want.mode, got.mode);
            errors++;
        end
        if (got.target_offset !== want.target_offset) begin
            $error("target_offset: expected %0d, got %0d", want.target_offset, got.target_offset);
            errors++;
        end
        if (got.blend_weight !== want.blend_weight) begin
            $error("blend_weight: expected %0d, got %0d", want.blend_weight, got.blend_weight);
            errors++;
        end
        if (got.entry_pulse !== want.entry_pulse) begin
            $error("entry_pulse: expected %0d, got %0d",
                   want.entry_pulse, got.entry_pulse);
            errors++;
        end
        if (got.filtered_accel !== want.filtered_accel) begin
            $error("filtered_accel: expected %0d, got %0d",
                   want.filtered_accel, got.filtered_accel);
            errors++;
        end
        if (got.timed_out !== want.timed_out) begin
            $error("timed_out: expected %0b, got %0b", want.timed_out, got.timed_out);
            errors++;
        end
        if (got.ctrl_was_active !== want.ctrl_was_active) begin
            $error("ctrl_was_active: expected %0b, got %0b",
                   want.ctrl_was_active, got.ctrl_was_active);
            errors++;
        end
    endtask

    // Both channels sampled on the edge itself; outputs are checked before
    // the new input is predicted so a result never matches its own item.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) check_result(m_data);
            if (s_valid && s_ready) expected_results.push_back(sequencer_step(s_data));
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    int hold_served = 0;
    int hold_left   = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_ready     <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: too long without any transfer on either channel.
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[accel_feedforward_sequencer] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers.
    // ------------------------------------------------------------------

    // Offer one item; valid stays up after the transfer until the next call
    // either replaces the payload or drops valid for a gap.
    task automatic send_item(input afs_pkg::in_item_t item);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop offering and let every pending result come back.
    // One edge first so the last transfer is already queued.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write all eight registers from next_cfg once the block is idle.
    task automatic load_config();
        int i;
        wait_drained();
        for (i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_wdata <= next_cfg[i];
            reg_val[i] = 32'(next_cfg[i] & reg_mask(3'(i)));
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic afs_pkg::in_item_t make_item(input logic act, input int accel,
                                                    input int perr,
                                                    input logic [31:0] cmd,
                                                    input logic [31:0] meas,
                                                    input logic fb_ok, input logic en,
                                                    input logic [31:0] now);
        afs_pkg::in_item_t it;
        it.action          = act;
        it.accel_sample    = 16'(accel);
        it.vision_err      = 16'(perr);
        it.commanded_pulse = cmd;
        it.measured_pulse  = meas;
        it.feedback_valid  = fb_ok;
        it.enable_ff       = en;
        it.now_ms          = now;
        return it;
    endfunction

    function automatic void random_config();
        int enter;
        enter = $urandom_range(0, 3000);
        next_cfg[afs_pkg::CFG_FEED_GAIN]     = 16'($urandom);
        next_cfg[afs_pkg::CFG_FILTER_ALPHA]  = ($urandom_range(9) == 0)
                                             ? 16'($urandom)
                                             : 16'($urandom_range(8000, 65535));
        next_cfg[afs_pkg::CFG_MAX_OFFSET]    = 16'($urandom);    // top bit must be dropped
        next_cfg[afs_pkg::CFG_ENTER_THRESH]  = 16'(enter);
        next_cfg[afs_pkg::CFG_EXIT_THRESH]   = 16'($urandom_range(0, enter));
        next_cfg[afs_pkg::CFG_ENTER_CONFIRM] = 16'($urandom_range(0, 40));
        next_cfg[afs_pkg::CFG_EXIT_CONFIRM]  = 16'($urandom_range(0, 80));
        next_cfg[afs_pkg::CFG_RETURN_TMO]    = 16'($urandom_range(0, 400));
    endfunction

    function automatic void extreme_config(input bit top);
        int i;
        for (i = 0; i < 8; i++) next_cfg[i] = top ? 16'hFFFF : 16'h0000;
        next_cfg[afs_pkg::CFG_FEED_GAIN] = top ? 16'h7FFF : 16'h8000;
    endfunction

    // Mostly well-formed episodes: steady clock, held acceleration level,
    // pipe positions near a center; with stale gaps and noise mixed in.
    task automatic send_random_items(input int count);
        afs_pkg::in_item_t item;
        int                n, roll, mag, lvl, ofs;
        for (n = 0; n < count; n++) begin
            if (episode_left == 0) begin
                case ($urandom_range(3))
                    0: accel_level = 0;
                    1: accel_level = int'($urandom_range(0, 60));
                    2: accel_level = int'($urandom_range(0, 4000));
                    default: accel_level = int'($signed(16'($urandom)));
                endcase
                if ($urandom_range(1)) accel_level = -accel_level;
                cmd_center   = $urandom;
                meas_center  = $urandom;
                episode_left = $urandom_range(3, 40);
            end
            episode_left--;

            roll = $urandom_range(99);
            if (roll < 85) clock_ms += $urandom_range(0, 15);
            else if (roll < 93) clock_ms += $urandom_range(16, 140);
            else if (roll < 96) clock_ms += 150 + $urandom_range(0, 1);  // gap limit edge
            else if (roll < 99) clock_ms += $urandom_range(151, 2000);
            else clock_ms += $urandom;
            item.now_ms = clock_ms;
            item.action = ($urandom_range(99) < 7) ? ACT_CHECK : ACT_SAMPLE;

            if ($urandom_range(19) == 0) begin
                item.accel_sample = 16'($urandom);
            end else begin
                lvl = accel_level + int'($urandom_range(0, 200)) - 100;
                if (lvl > 32767) lvl = 32767;
                else if (lvl < -32768) lvl = -32768;
                item.accel_sample = 16'(lvl);
            end

            roll = $urandom_range(99);
            if (roll < 75) mag = $urandom_range(0, 400);
            else if (roll < 85) mag = $urandom_range(410, 420);   // around the cutoff
            else mag = $urandom_range(0, 32768);
            item.vision_err = 16'($urandom_range(1) ? -mag : mag);

            item.commanded_pulse = ($urandom_range(9) < 7) ? cmd_center : $urandom;
            roll = $urandom_range(99);
            if (roll < 50) ofs = $urandom_range(0, 60);
            else ofs = $urandom_range(0, 5000);
            if ($urandom_range(1)) ofs = -ofs;
            item.measured_pulse = (roll < 85) ? meas_center + 32'(ofs) : $urandom;

            item.feedback_valid = ($urandom_range(99) >= 4);
            item.enable_ff      = ($urandom_range(99) >= 4);
            send_item(item);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset register values: seeding, gating, blend edges, gap limit,
    // timeout checks with and without control running, time wrap.
    task automatic test_directed_defaults();
        logic [31:0] t;
        t = 32'hFFFF_FFF8;
        send_item(make_item(ACT_CHECK, 0, 0, 32'd7, 32'd0, 1'b1, 1'b1, t));   // nothing seen yet
        send_item(make_item(ACT_SAMPLE, 32767, -32768, 32'h7FFF_FFFF, 32'h8000_0000,
                            1'b1, 1'b1, t));                                 // seed
        send_item(make_item(ACT_SAMPLE, 32767, 0, 32'd100, 32'd5000, 1'b1, 1'b0, t + 1));
        send_item(make_item(ACT_SAMPLE, 32767, 0, 32'd100, 32'd5000, 1'b0, 1'b1, t + 2));
        send_item(make_item(ACT_SAMPLE, 32767, 0, 32'd200, 32'd6000, 1'b1, 1'b1, t + 3));
        send_item(make_item(ACT_SAMPLE, 32767, 10, 32'd300, 32'd6100, 1'b1, 1'b1, t + 13));
        send_item(make_item(ACT_SAMPLE, -32768, 415, 32'd300, 32'd6100, 1'b1, 1'b1, t + 14));
        send_item(make_item(ACT_SAMPLE, -32768, 416, 32'd400, 32'd6100, 1'b1, 1'b1, t + 15));
        send_item(make_item(ACT_CHECK, 0, 0, 32'd1, 32'd0, 1'b1, 1'b1, t + 165));  // gap == limit
        send_item(make_item(ACT_SAMPLE, 32767, 0, 32'd500, 32'd7000, 1'b1, 1'b1, t + 165));
        send_item(make_item(ACT_SAMPLE, 32767, -415, 32'd600, 32'd7000, 1'b1, 1'b1, t + 175));
        send_item(make_item(ACT_CHECK, 0, 0, 32'hDEAD_BEEF, 32'd0, 1'b1, 1'b1, t + 326));
        send_item(make_item(ACT_SAMPLE, -32768, 0, 32'd700, 32'd100, 1'b1, 1'b1, t + 400));
        send_item(make_item(ACT_SAMPLE, -32768, 0, 32'd800, 32'd100, 1'b1, 1'b1, t + 401));
        send_item(make_item(ACT_SAMPLE, -32768, 0, 32'd900, 32'd100, 1'b1, 1'b1, t + 411));
        send_item(make_item(ACT_SAMPLE, 0, 0, 32'hFFFF_0000, 32'd0, 1'b1, 1'b1, t + 562));
        send_item(make_item(ACT_CHECK, 0, 0, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, t + 713));
        // a stretch of random traffic still on reset register values
        clock_ms = $urandom;
        send_random_items(100);
    endtask

    // Fast filter and zero confirm times: active, exit, return, tolerance edge.
    task automatic test_directed_sequence();
        logic [31:0] t;
        next_cfg[afs_pkg::CFG_FEED_GAIN]     = 16'h8000;
        next_cfg[afs_pkg::CFG_FILTER_ALPHA]  = 16'hFFFF;
        next_cfg[afs_pkg::CFG_MAX_OFFSET]    = 16'hFFFF;
        next_cfg[afs_pkg::CFG_ENTER_THRESH]  = 16'd0;
        next_cfg[afs_pkg::CFG_EXIT_THRESH]   = 16'd10;
        next_cfg[afs_pkg::CFG_ENTER_CONFIRM] = 16'd0;
        next_cfg[afs_pkg::CFG_EXIT_CONFIRM]  = 16'd0;
        next_cfg[afs_pkg::CFG_RETURN_TMO]    = 16'hFFFF;
        load_config();
        t = $urandom;
        send_item(make_item(ACT_SAMPLE, 0, 0, 32'h1234_5678, 32'd0, 1'b1, 1'b1, t));
        send_item(make_item(ACT_SAMPLE, 20000, 0, 32'd11, 32'd1000, 1'b1, 1'b1, t + 1));
        send_item(make_item(ACT_SAMPLE, 20000, -5, 32'd12, 32'd1000, 1'b1, 1'b1, t + 2));
        send_item(make_item(ACT_SAMPLE, 0, 0, 32'd13, 32'd1000, 1'b1, 1'b1, t + 3));
        send_item(make_item(ACT_SAMPLE, 0, 0, 32'd14, 32'd1000, 1'b1, 1'b1, t + 4));
        send_item(make_item(ACT_SAMPLE, 0, 0, 32'd15, 32'd1049, 1'b1, 1'b1, t + 5));  // just out
        send_item(make_item(ACT_SAMPLE, 0, 0, 32'd16, 32'd952, 1'b1, 1'b1, t + 6));   // just in
    endtask

    // Random traffic under each idling pattern and several register settings.
    task automatic test_random_idling();
        int idle_set [4]  = '{0, 45, 0, 15};
        int stall_set [4] = '{0, 0, 45, 15};
        int p;
        for (p = 0; p < 4; p++) begin
            idle_pct  = idle_set[p];
            stall_pct = stall_set[p];
            random_config();
            load_config();
            send_random_items(110);
            random_config();
            load_config();
            send_random_items(110);
            extreme_config(p[0]);
            load_config();
            send_random_items(50);
        end
    endtask

    // Long receiver hold-off so the block fills and stalls its input,
    // then a full sender pause until everything has come back.
    task automatic test_backpressure();
        random_config();
        load_config();
        idle_pct  = 0;
        stall_pct = 0;
        hold_requests <= hold_requests + 1;
        send_random_items(40);
        wait_drained();
        send_random_items(20);
        wait_drained();
    endtask

    initial begin
        model_reset();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_defaults();
        test_directed_sequence();
        test_random_idling();
        test_backpressure();
        wait_drained();

        if (errors == 0 && expected_results.size() == 0) begin
            $display("[accel_feedforward_sequencer] OK");
        end else begin
            $display("[accel_feedforward_sequencer] ERROR");
        end
        $finish;
    end

endmodule
